// ----- design/nmcs_pkg.sv -----
`default_nettype none

package nmcs_pkg;

   // default grid store side
   localparam int MAX_SIDE_DEF = 16;

   // grid size after reset
   localparam logic [4:0] GRID_SIZE_RST = 5'd16;

   // item modes
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // input item
   typedef struct packed {
      logic       mode;
      logic [3:0] row;
      logic [3:0] column;
      logic [1:0] cell_type;
      logic       never_visited;
   } req_payload_type;

   // result item
   typedef struct packed {
      logic [4:0] distance;
      logic       found;
   } rsp_payload_type;

   // one stored cell
   typedef struct packed {
      logic       fresh;
      logic [1:0] ctype;
   } cell_type;

   // store port control
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   // sequencer steps
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_CLEAR    = 3'd0;
   localparam logic [STEP_W-1:0] STEP_FETCH    = 3'd1;
   localparam logic [STEP_W-1:0] STEP_DISPATCH = 3'd2;
   localparam logic [STEP_W-1:0] STEP_SCAN     = 3'd3;
   localparam logic [STEP_W-1:0] STEP_DRAIN    = 3'd4;
   localparam logic [STEP_W-1:0] STEP_REPLY    = 3'd5;
   localparam logic [STEP_W-1:0] STEP_WRITE    = 3'd6;

   // jump conditions
   localparam int COND_W = 3;
   localparam logic [COND_W-1:0] COND_ALWAYS    = 3'd0;
   localparam logic [COND_W-1:0] COND_CLR_MORE  = 3'd1;
   localparam logic [COND_W-1:0] COND_ACCEPT    = 3'd2;
   localparam logic [COND_W-1:0] COND_IS_WRITE  = 3'd3;
   localparam logic [COND_W-1:0] COND_SCAN_MORE = 3'd4;
   localparam logic [COND_W-1:0] COND_RSP_BUSY  = 3'd5;

   // control word: datapath strobes, then condition and both targets
   typedef struct packed {
      logic              clr_wr;
      logic              fetch;
      logic              scan_init;
      logic              scan_rd;
      logic              reply_query;
      logic              reply_write;
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] jump_true;
      logic [STEP_W-1:0] jump_false;
   } ucode_type;

   // control store
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = '0;
      unique case (step)
         STEP_CLEAR: begin
            w.clr_wr     = 1'b1;
            w.cond       = COND_CLR_MORE;
            w.jump_true  = STEP_CLEAR;
            w.jump_false = STEP_FETCH;
         end
         STEP_FETCH: begin
            w.fetch      = 1'b1;
            w.cond       = COND_ACCEPT;
            w.jump_true  = STEP_DISPATCH;
            w.jump_false = STEP_FETCH;
         end
         STEP_DISPATCH: begin
            w.scan_init  = 1'b1;
            w.cond       = COND_IS_WRITE;
            w.jump_true  = STEP_WRITE;
            w.jump_false = STEP_SCAN;
         end
         STEP_SCAN: begin
            w.scan_rd    = 1'b1;
            w.cond       = COND_SCAN_MORE;
            w.jump_true  = STEP_SCAN;
            w.jump_false = STEP_DRAIN;
         end
         STEP_DRAIN: begin
            w.cond       = COND_ALWAYS;
            w.jump_true  = STEP_REPLY;
            w.jump_false = STEP_REPLY;
         end
         STEP_REPLY: begin
            w.reply_query = 1'b1;
            w.cond        = COND_RSP_BUSY;
            w.jump_true   = STEP_REPLY;
            w.jump_false  = STEP_FETCH;
         end
         STEP_WRITE: begin
            w.reply_write = 1'b1;
            w.cond        = COND_RSP_BUSY;
            w.jump_true   = STEP_WRITE;
            w.jump_false  = STEP_FETCH;
         end
         default: begin
            w.cond       = COND_ALWAYS;
            w.jump_true  = STEP_FETCH;
            w.jump_false = STEP_FETCH;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ----- design/nearest_matching_cell_search.sv -----
// Items are taken one at a time: a write item passes from dispatch to the write step;
// a query passes from dispatch through the scan and drain steps to the reply step.
// Scan speed is set by the single read port of the cell store, which the scan loop reads
// once a cycle; each reply step waits while the last result is untaken, then fetches.
// Reset: a clearing pass over all MAX_SIDE*MAX_SIDE cells (256 by default) sets every
// cell to type 0, visited, with req_ready low; grid_size resets to 16.
`default_nettype none

module nearest_matching_cell_search
   import nmcs_pkg::*;
#(
   parameter int MAX_SIDE = MAX_SIDE_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_data,
   input  wire logic            csr_we,
   input  wire logic [4:0]      csr_wdata
);

   localparam int DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = $clog2(MAX_SIDE);
   localparam int SDW   = $clog2(MAX_SIDE + 1);
   localparam int CW    = (SDW > 5) ? SDW : 5;
   localparam int PW    = (IW > 4) ? IW : 4;
   localparam int DW    = ((SDW > PW) ? SDW : PW) + 1;

   logic [STEP_W-1:0] pc_ff, pc_in;
   logic [4:0]        grid_size_ff, grid_size_in;
   logic [AW-1:0]     clr_ff, clr_in;
   req_payload_type   req_ff, req_in;
   logic [IW-1:0]     r_ff, r_in, c_ff, c_in;
   logic [IW-1:0]     rrow_ff, rrow_in, rcol_ff, rcol_in;
   logic              rdv_ff, rdv_in;
   logic [DW-1:0]     best_ff, best_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff, rsp_data_in;

   ucode_type         uw;
   logic              take;
   logic              accept;
   logic              clr_last;
   logic              last_r, last_c;
   logic              rsp_busy;
   logic [CW-1:0]     gs_w, max_w, side_w;
   logic [SDW-1:0]    side, side_m1;
   logic [DW-1:0]     limit;
   logic [PW-1:0]     rp, qr, cp, qc, dr, dc;
   logic [DW-1:0]     cell_dist;
   logic              hit;
   logic              wr_in_range;
   logic              found;
   mem_ctl_type       mem_ctl;
   logic [AW-1:0]     wr_addr, rd_addr;
   cell_type          wr_data, rd_data;

   // fetch the control word
   assign uw = ucode_rom(pc_ff);

   // active side, clamped to 1 .. MAX_SIDE
   always_comb begin
      gs_w  = CW'(grid_size_ff);
      max_w = CW'(MAX_SIDE);
      if (gs_w == '0) begin
         side_w = CW'(1);
      end else if (gs_w > max_w) begin
         side_w = max_w;
      end else begin
         side_w = gs_w;
      end
   end
   assign side    = side_w[SDW-1:0];
   assign side_m1 = side - SDW'(1);
   assign limit   = DW'(side) << 1;

   // scan position and loop ends
   assign last_c   = (SDW'(c_ff) == side_m1);
   assign last_r   = (SDW'(r_ff) == side_m1);
   assign clr_last = (clr_ff == AW'(DEPTH - 1));
   assign rsp_busy = rsp_valid_ff && !rsp_ready;

   assign req_ready = uw.fetch;
   assign accept    = req_valid && uw.fetch;

   // jump condition
   always_comb begin
      unique case (uw.cond)
         COND_ALWAYS:    take = 1'b1;
         COND_CLR_MORE:  take = !clr_last;
         COND_ACCEPT:    take = req_valid;
         COND_IS_WRITE:  take = (req_ff.mode == MODE_WRITE);
         COND_SCAN_MORE: take = !(last_r && last_c);
         COND_RSP_BUSY:  take = rsp_busy;
         default:        take = 1'b1;
      endcase
   end
   assign pc_in = take ? uw.jump_true : uw.jump_false;

   // distance of the cell just read
   always_comb begin
      rp        = PW'(rrow_ff);
      qr        = PW'(req_ff.row);
      cp        = PW'(rcol_ff);
      qc        = PW'(req_ff.column);
      dr        = (rp > qr) ? (rp - qr) : (qr - rp);
      dc        = (cp > qc) ? (cp - qc) : (qc - cp);
      cell_dist = DW'(dr) + DW'(dc);
   end
   assign hit = rdv_ff && rd_data.fresh && (rd_data.ctype == req_ff.cell_type)
                && (cell_dist < best_ff);

   // store ports
   assign wr_in_range = (int'(req_ff.row) < MAX_SIDE) && (int'(req_ff.column) < MAX_SIDE);
   always_comb begin
      mem_ctl.wr_en = uw.clr_wr || (uw.reply_write && wr_in_range);
      mem_ctl.rd_en = uw.scan_rd;
      if (uw.clr_wr) begin
         wr_addr = clr_ff;
         wr_data = '0;
      end else begin
         wr_addr = AW'(int'(req_ff.row) * MAX_SIDE + int'(req_ff.column));
         wr_data.fresh = req_ff.never_visited;
         wr_data.ctype = req_ff.cell_type;
      end
      rd_addr = AW'(int'(r_ff) * MAX_SIDE + int'(c_ff));
   end

   // datapath next values
   assign found = (best_ff < limit);
   always_comb begin
      grid_size_in = csr_we ? csr_wdata : grid_size_ff;
      clr_in       = uw.clr_wr ? clr_ff + AW'(1) : clr_ff;
      req_in       = accept ? req_data : req_ff;
      rdv_in       = uw.scan_rd;
      rrow_in      = uw.scan_rd ? r_ff : rrow_ff;
      rcol_in      = uw.scan_rd ? c_ff : rcol_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      best_in      = hit ? cell_dist : best_ff;
      if (uw.scan_init) begin
         r_in    = '0;
         c_in    = '0;
         best_in = limit;
      end else if (uw.scan_rd) begin
         if (last_c) begin
            c_in = '0;
            r_in = r_ff + IW'(1);
         end else begin
            c_in = c_ff + IW'(1);
         end
      end
      // hold the result until taken, load a new one once the slot frees
      rsp_valid_in = rsp_busy;
      rsp_data_in  = rsp_data_ff;
      if (!rsp_busy && uw.reply_query) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.found    = found;
         rsp_data_in.distance = found ? best_ff[4:0] : 5'(limit - DW'(1));
      end else if (!rsp_busy && uw.reply_write) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_CLEAR;
         grid_size_ff <= GRID_SIZE_RST;
         clr_ff       <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         grid_size_ff <= grid_size_in;
         clr_ff       <= clr_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      r_ff        <= r_in;
      c_ff        <= c_in;
      rrow_ff     <= rrow_in;
      rcol_ff     <= rcol_in;
      best_ff     <= best_in;
      rsp_data_ff <= rsp_data_in;
   end

   nmcs_store #(
      .MAX_SIDE(MAX_SIDE)
   ) u_store (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // best distance only shrinks while compares run
   a_best_shrinks: assert property (@(posedge clock) disable iff (reset)
      rdv_ff |=> (best_ff <= $past(best_ff)))
      else $error("best distance grew during a scan");

   // a result appears only from a reply step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(pc_ff) == STEP_REPLY || $past(pc_ff) == STEP_WRITE))
      else $error("result raised outside a reply step");

   // a write item answers with zeros
   a_write_reply: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == STEP_WRITE && !rsp_busy) |=>
         (rsp_valid_ff && !rsp_data_ff.found && rsp_data_ff.distance == 5'd0))
      else $error("write item reply not zero");

   // no item taken while the store is being cleared
   a_no_fetch_in_clear: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == STEP_CLEAR) |-> !req_ready)
      else $error("item accepted during clearing pass");

endmodule

`default_nettype wire

// ----- design/nmcs_store.sv -----
`default_nettype none

module nmcs_store
   import nmcs_pkg::*;
#(
   parameter int MAX_SIDE = MAX_SIDE_DEF
) (
   input  wire logic                                  clock,
   input  wire mem_ctl_type                           ctl,
   input  wire logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]  wr_addr,
   input  wire cell_type                              wr_data,
   input  wire logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]  rd_addr,
   output cell_type                                   rd_data
);

   localparam int DEPTH = MAX_SIDE * MAX_SIDE;

   cell_type mem_ff [DEPTH];
   cell_type rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- tb/sv/tb_nearest_matching_cell_search.sv -----
`timescale 1ns / 100ps

module tb_nearest_matching_cell_search;
   import nmcs_pkg::*;

   localparam int STORE_CELLS = MAX_SIDE_DEF * MAX_SIDE_DEF;
   localparam int PHASE_COUNT = 13;
   localparam int PHASE_ITEMS = 140;
   localparam int LONG_HOLD = 400;
   // grid sizes per random phase: extremes, clamped values and small grids
   localparam logic [4:0] PHASE_SIZES [PHASE_COUNT] = '{
      5'd1, 5'd4, 5'd16, 5'd3, 5'd0, 5'd8, 5'd31, 5'd2, 5'd6, 5'd12, 5'd5, 5'd16, 5'd17
   };

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic            csr_we = 1'b0;
   logic [4:0]      csr_wdata = '0;

   // shadow of the cell store and the grid size register
   logic [1:0]      cell_kind [STORE_CELLS];
   bit              cell_open [STORE_CELLS];
   logic [4:0]      grid_reg;

   req_payload_type queued_requests [$];
   rsp_payload_type awaited_replies [$];

   bit              req_taken;
   bit              calm_phase;
   bit              long_hold_done;
   int unsigned     send_gap;
   int unsigned     rsp_hold;
   int unsigned     fail_count;
   int unsigned     replies_seen;
   int unsigned     queries_sent;
   int unsigned     matches_seen;
   int unsigned     settings_used;

   nearest_matching_cell_search dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // clamp the register to the side actually searched
   function automatic int unsigned active_side(input logic [4:0] gs);
      if (gs == 5'd0) return 1;
      if (gs > 5'(MAX_SIDE_DEF)) return MAX_SIDE_DEF;
      return gs;
   endfunction

   // apply one item to the shadow store and return the reply it causes
   function automatic rsp_payload_type search_grid(input req_payload_type it);
      rsp_payload_type res;
      int unsigned side, best, d, idx;
      res = '0;
      if (it.mode == MODE_WRITE) begin
         idx = it.row * MAX_SIDE_DEF + it.column;
         cell_kind[idx] = it.cell_type;
         cell_open[idx] = it.never_visited;
         return res;
      end
      side = active_side(grid_reg);
      best = 2 * side;
      for (int r = 0; r < side; r++) begin
         for (int c = 0; c < side; c++) begin
            idx = r * MAX_SIDE_DEF + c;
            if (cell_open[idx] && cell_kind[idx] == it.cell_type) begin
               d = ((r > it.row) ? r - it.row : it.row - r)
                 + ((c > it.column) ? c - it.column : it.column - c);
               if (d < best) best = d;
            end
         end
      end
      if (best < 2 * side) begin
         res.distance = 5'(best);
         res.found = 1'b1;
      end else begin
         res.distance = 5'(2 * side - 1);
         res.found = 1'b0;
      end
      return res;
   endfunction

   function automatic req_payload_type cell_req(input logic mode, input int unsigned row,
                                                input int unsigned col, input int unsigned kind,
                                                input bit fresh);
      req_payload_type it;
      it.mode = mode;
      it.row = 4'(row);
      it.column = 4'(col);
      it.cell_type = 2'(kind);
      it.never_visited = fresh;
      return it;
   endfunction

   // mostly inside the active grid, sometimes anywhere in the store
   function automatic req_payload_type random_request(input int unsigned side);
      req_payload_type it;
      it.mode = ($urandom_range(99) < 55) ? MODE_WRITE : MODE_QUERY;
      if ($urandom_range(9) < 8) begin
         it.row = 4'($urandom_range(side - 1));
         it.column = 4'($urandom_range(side - 1));
      end else begin
         it.row = 4'($urandom_range(15));
         it.column = 4'($urandom_range(15));
      end
      it.cell_type = 2'($urandom_range(3));
      it.never_visited = ($urandom_range(9) < 7);
      return it;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   task automatic write_grid(input logic [4:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      grid_reg = value;
      settings_used++;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // wait for every item to go out and every reply to come back
   task automatic settle();
      while (queued_requests.size() != 0 || req_valid || awaited_replies.size() != 0)
         @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   // driver: hold an item until taken, then gap or offer the next one
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap != 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (queued_requests.size() != 0) begin
            req_data <= queued_requests.pop_front();
            req_valid <= 1'b1;
            send_gap = (calm_phase || $urandom_range(2) != 0) ? 0 : pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus one long hold-off to back the block up
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (!long_hold_done && replies_seen >= 30) begin
         long_hold_done = 1'b1;
         rsp_hold = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (rsp_hold != 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else begin
         if (!calm_phase && $urandom_range(3) == 0) rsp_hold = pick_gap();
         rsp_ready <= (rsp_hold == 0);
      end
   end

   // monitor: predict on each accepted item, check each reply in order
   always @(posedge clock) begin
      rsp_payload_type want;
      req_taken = !reset && req_valid && req_ready;
      if (req_taken) begin
         if (req_data.mode == MODE_QUERY) queries_sent++;
         awaited_replies.push_back(search_grid(req_data));
      end
      if (!reset && rsp_valid && rsp_ready) begin
         replies_seen++;
         if (awaited_replies.size() == 0) begin
            $error("unexpected reply: distance %0d found %0b", rsp_data.distance,
                   rsp_data.found);
            fail_count++;
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_data.distance !== want.distance) begin
               $error("distance mismatch: expected %0d, got %0d", want.distance,
                      rsp_data.distance);
               fail_count++;
            end
            if (rsp_data.found !== want.found) begin
               $error("found mismatch: expected %0b, got %0b", want.found, rsp_data.found);
               fail_count++;
            end
            if (want.found) matches_seen++;
         end
      end
   end

   initial begin
      int unsigned side;
      for (int i = 0; i < STORE_CELLS; i++) begin
         cell_kind[i] = 2'd0;
         cell_open[i] = 1'b0;
      end
      grid_reg = GRID_SIZE_RST;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // full grid: empty store, far corners, visited cells, query flag ignored
      calm_phase = 1'b1;
      queued_requests.push_back(cell_req(MODE_QUERY, 0, 0, 0, 0));
      queued_requests.push_back(cell_req(MODE_QUERY, 15, 15, 3, 1));
      queued_requests.push_back(cell_req(MODE_WRITE, 15, 15, 3, 1));
      queued_requests.push_back(cell_req(MODE_QUERY, 0, 0, 3, 0));
      queued_requests.push_back(cell_req(MODE_QUERY, 15, 15, 3, 1));
      queued_requests.push_back(cell_req(MODE_WRITE, 0, 0, 2, 1));
      queued_requests.push_back(cell_req(MODE_QUERY, 15, 15, 2, 0));
      queued_requests.push_back(cell_req(MODE_WRITE, 15, 15, 3, 0));
      queued_requests.push_back(cell_req(MODE_QUERY, 0, 0, 3, 0));
      queued_requests.push_back(cell_req(MODE_WRITE, 7, 8, 1, 1));
      queued_requests.push_back(cell_req(MODE_QUERY, 7, 8, 1, 0));
      queued_requests.push_back(cell_req(MODE_QUERY, 0, 15, 1, 1));
      queued_requests.push_back(cell_req(MODE_WRITE, 0, 15, 0, 1));
      queued_requests.push_back(cell_req(MODE_QUERY, 15, 0, 0, 0));
      settle();

      // size zero acts as one; origin outside; write outside the active grid
      write_grid(5'd0);
      queued_requests.push_back(cell_req(MODE_QUERY, 0, 0, 2, 0));
      queued_requests.push_back(cell_req(MODE_QUERY, 15, 15, 2, 0));
      queued_requests.push_back(cell_req(MODE_WRITE, 3, 3, 1, 1));
      queued_requests.push_back(cell_req(MODE_QUERY, 0, 0, 1, 0));
      settle();

      // oversize clamps to full grid; the earlier outside write now shows up
      write_grid(5'd31);
      queued_requests.push_back(cell_req(MODE_QUERY, 0, 0, 1, 0));
      queued_requests.push_back(cell_req(MODE_QUERY, 15, 15, 3, 0));
      settle();

      // match beyond twice the side counts as not found
      write_grid(5'd2);
      queued_requests.push_back(cell_req(MODE_WRITE, 1, 1, 3, 1));
      queued_requests.push_back(cell_req(MODE_QUERY, 15, 15, 3, 0));
      queued_requests.push_back(cell_req(MODE_QUERY, 1, 0, 3, 0));
      settle();

      write_grid(5'd17);
      queued_requests.push_back(cell_req(MODE_QUERY, 15, 15, 3, 0));
      queued_requests.push_back(cell_req(MODE_WRITE, 0, 0, 0, 0));
      settle();

      // random phases, one grid size each, drained before the next setting
      for (int p = 0; p < PHASE_COUNT; p++) begin
         calm_phase = (p % 4 == 1);
         write_grid(PHASE_SIZES[p]);
         side = active_side(grid_reg);
         repeat (PHASE_ITEMS) queued_requests.push_back(random_request(side));
         settle();
      end

      repeat (20) @(negedge clock);
      $display("covered %0d replies, %0d queries of which %0d matched, over %0d grid settings",
               replies_seen, queries_sent, matches_seen, settings_used);
      if (fail_count == 0) begin
         $display("nearest_matching_cell_search test passed");
      end else begin
         $display("nearest_matching_cell_search test failed");
      end
      $finish;
   end

   // give up well after the slowest legal run
   initial begin
      #30_000_000;
      $display("nearest_matching_cell_search test failed");
      $finish;
   end

endmodule

// ----- sim.f -----
design/nmcs_pkg.sv
design/nmcs_store.sv
design/nearest_matching_cell_search.sv
tb/sv/tb_nearest_matching_cell_search.sv
